// ===== hw/rtl/sfrc_pkg.sv =====
// Shared types and constants for the serial frame receiver with sum check.
// Used by sfrc_parser, sfrc_out_fifo and serial_frame_receiver_checksum.
package sfrc_pkg;

  localparam int LONG_PAYLOAD_DEF  = 500;
  localparam int SHORT_PAYLOAD_DEF = 128;
  localparam int SHORT_FRAME_DEF   = 16;

  localparam logic [7:0] LEAD_DONE = 8'h00;
  localparam logic [7:0] LEAD_PKT  = 8'h01;
  localparam logic [7:0] LEAD_ENQ  = 8'h05;
  localparam logic [7:0] LEAD_ACK  = 8'h06;

  localparam logic [15:0] TYPE_OK = 16'h4f4b;
  localparam logic [15:0] TYPE_DE = 16'h4445;
  localparam logic [15:0] TYPE_SB = 16'h5342;
  localparam logic [15:0] TYPE_DT = 16'h4454;

  typedef enum logic [2:0] {
    EV_BODY      = 3'd0,
    EV_ACK       = 3'd1,
    EV_DONE      = 3'd2,
    EV_ENQ       = 3'd3,
    EV_BAD_LEAD  = 3'd4,
    EV_UNKNOWN   = 3'd5,
    EV_SHORT_END = 3'd6,
    EV_DATA_END  = 3'd7
  } event_e;

  typedef struct packed {
    event_e      ev;
    logic [7:0]  body_byte;
    logic [8:0]  body_index;
    logic [15:0] type_code;
    logic [15:0] packet_number;
    logic [15:0] data_length;
    logic        checksum_ok;
  } result_t;

endpackage

// ===== hw/rtl/sfrc_parser.sv =====
// Frame parser: phase tracking, header capture, running sum and result build.
// Depends on sfrc_pkg.
module sfrc_parser #(
  parameter int LONG_PAYLOAD  = sfrc_pkg::LONG_PAYLOAD_DEF,
  parameter int SHORT_PAYLOAD = sfrc_pkg::SHORT_PAYLOAD_DEF,
  parameter int SHORT_FRAME   = sfrc_pkg::SHORT_FRAME_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              payload_mode_i,
  output logic              push_o,
  output sfrc_pkg::result_t result_o
);

  localparam int MaxPay = (LONG_PAYLOAD > SHORT_PAYLOAD) ? LONG_PAYLOAD : SHORT_PAYLOAD;
  localparam int MaxLen = (12 + MaxPay > SHORT_FRAME) ? 12 + MaxPay : SHORT_FRAME;
  localparam int PiuW   = $clog2(MaxPay + 1);
  localparam int PosW   = $clog2(MaxLen + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_SHORT,
    PH_DATA
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [15:0]       sum_q, sum_d;
  logic [15:0]       type_q, type_d;
  logic [15:0]       num_q, num_d;
  logic [15:0]       len_q, len_d;
  logic [15:0]       rsum_q, rsum_d;
  logic [PiuW-1:0]   piu_q, piu_d;

  logic [PosW-1:0]   pay_base;
  logic [15:0]       add_sum;
  logic [PosW-1:0]   pos_next;
  logic [PosW-1:0]   data_idx;
  logic [15:0]       len_shift;

  assign pay_base  = PosW'(piu_q) + PosW'(8);
  assign add_sum   = sum_q + {8'h00, rx_byte_i};
  assign pos_next  = pos_q + PosW'(1);
  assign data_idx  = pos_q - PosW'(8);
  assign len_shift = {len_q[7:0], rx_byte_i};

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    type_d   = type_q;
    num_d    = num_q;
    len_d    = len_q;
    rsum_d   = rsum_q;
    piu_d    = piu_q;
    push_o   = 1'b0;
    result_o = '0;
    if (accept_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == sfrc_pkg::LEAD_ACK) begin
            push_o      = 1'b1;
            result_o.ev = sfrc_pkg::EV_ACK;
          end else if (rx_byte_i == sfrc_pkg::LEAD_DONE) begin
            push_o      = 1'b1;
            result_o.ev = sfrc_pkg::EV_DONE;
          end else if (rx_byte_i == sfrc_pkg::LEAD_ENQ) begin
            push_o      = 1'b1;
            result_o.ev = sfrc_pkg::EV_ENQ;
          end else if (rx_byte_i != sfrc_pkg::LEAD_PKT) begin
            push_o      = 1'b1;
            result_o.ev = sfrc_pkg::EV_BAD_LEAD;
          end else begin
            phase_d = PH_HEAD;
            pos_d   = PosW'(1);
            sum_d   = '0;
            type_d  = '0;
            num_d   = '0;
            len_d   = '0;
            rsum_d  = '0;
            piu_d   = '0;
          end
        end
        PH_HEAD: begin
          pos_d = pos_next;
          if (pos_q != PosW'(1)) begin
            sum_d  = add_sum;
            type_d = {type_q[7:0], rx_byte_i};
            if (pos_q != PosW'(2)) begin
              if (type_d == sfrc_pkg::TYPE_OK || type_d == sfrc_pkg::TYPE_DE ||
                  type_d == sfrc_pkg::TYPE_SB) begin
                phase_d = PH_SHORT;
              end else if (type_d == sfrc_pkg::TYPE_DT) begin
                phase_d = PH_DATA;
              end else begin
                phase_d            = PH_IDLE;
                pos_d              = '0;
                push_o             = 1'b1;
                result_o.ev        = sfrc_pkg::EV_UNKNOWN;
                result_o.type_code = type_d;
              end
            end
          end
        end
        PH_SHORT: begin
          pos_d = pos_next;
          if (pos_q < PosW'(SHORT_FRAME - 4)) begin
            sum_d               = add_sum;
            push_o              = 1'b1;
            result_o.ev         = sfrc_pkg::EV_BODY;
            result_o.body_byte  = rx_byte_i;
            result_o.body_index = 9'(pos_q - PosW'(4));
            result_o.type_code  = type_q;
          end else if (pos_q == PosW'(SHORT_FRAME - 4) ||
                       pos_q == PosW'(SHORT_FRAME - 3)) begin
            rsum_d = {rsum_q[7:0], rx_byte_i};
          end else if (pos_q >= PosW'(SHORT_FRAME - 1)) begin
            phase_d              = PH_IDLE;
            pos_d                = '0;
            push_o               = 1'b1;
            result_o.ev          = sfrc_pkg::EV_SHORT_END;
            result_o.type_code   = type_q;
            result_o.checksum_ok = (sum_q == rsum_q);
          end
        end
        PH_DATA: begin
          pos_d = pos_next;
          if (pos_q < PosW'(8)) begin
            sum_d = add_sum;
            if (pos_q < PosW'(6)) begin
              num_d = {num_q[7:0], rx_byte_i};
            end else begin
              len_d = len_shift;
              if (pos_q == PosW'(7)) begin
                piu_d = (payload_mode_i || len_shift == 16'(SHORT_PAYLOAD)) ?
                        PiuW'(SHORT_PAYLOAD) : PiuW'(LONG_PAYLOAD);
              end
            end
          end else if (pos_q < pay_base) begin
            sum_d = add_sum;
            if (16'(data_idx) < len_q) begin
              push_o                 = 1'b1;
              result_o.ev            = sfrc_pkg::EV_BODY;
              result_o.body_byte     = rx_byte_i;
              result_o.body_index    = 9'(data_idx);
              result_o.type_code     = type_q;
              result_o.packet_number = num_q;
              result_o.data_length   = len_q;
            end
          end else if (pos_q == pay_base || pos_q == pay_base + PosW'(1)) begin
            rsum_d = {rsum_q[7:0], rx_byte_i};
          end else if (pos_q >= pay_base + PosW'(3)) begin
            phase_d                = PH_IDLE;
            pos_d                  = '0;
            push_o                 = 1'b1;
            result_o.ev            = sfrc_pkg::EV_DATA_END;
            result_o.type_code     = type_q;
            result_o.packet_number = num_q;
            result_o.data_length   = len_q;
            result_o.checksum_ok   = (sum_q == rsum_q);
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      sum_q   <= '0;
      type_q  <= '0;
      num_q   <= '0;
      len_q   <= '0;
      rsum_q  <= '0;
      piu_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      type_q  <= type_d;
      num_q   <= num_d;
      len_q   <= len_d;
      rsum_q  <= rsum_d;
      piu_q   <= piu_d;
    end
  end

`ifndef ASSERT_OFF
  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (pos_q == '0))
    else $error("position not cleared in idle");
  a_data_piu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA && pos_q > PosW'(7)) |->
      (piu_q == PiuW'(SHORT_PAYLOAD) || piu_q == PiuW'(LONG_PAYLOAD)))
    else $error("payload size not set in data frame");
  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |-> !push_o)
    else $error("result without accepted byte");
`endif

endmodule

// ===== hw/rtl/sfrc_out_fifo.sv =====
// Two-entry output buffer: output register plus skid slot for result items.
// Depends on sfrc_pkg.
module sfrc_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfrc_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output sfrc_pkg::result_t data_o
);

  logic              v0_q, v1_q;
  sfrc_pkg::result_t s0_q, s1_q;
  logic              pop;

  assign pop     = v0_q && pop_ready_i;
  assign ready_o = !v1_q;
  assign valid_o = v0_q;
  assign data_o  = s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (pop) begin
      if (v1_q) begin
        v1_q <= 1'b0;
      end else begin
        v0_q <= push_i;
      end
    end else if (push_i) begin
      if (!v0_q) begin
        v0_q <= 1'b1;
      end else begin
        v1_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (v1_q) begin
        s0_q <= s1_q;
      end else begin
        s0_q <= data_i;
      end
    end else if (push_i) begin
      if (!v0_q) begin
        s0_q <= data_i;
      end else begin
        s1_q <= data_i;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !v1_q)
    else $error("push into full buffer");
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> v0_q)
    else $error("skid slot filled with empty output slot");
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && v1_q) |=> (v0_q && !v1_q))
    else $error("skid entry lost on pop");
`endif

endmodule

// ===== hw/rtl/serial_frame_receiver_checksum.sv =====
// Serial frame receiver with 16-bit sum check.
// Each result transaction is registered in the output buffer before it is presented on m_axis.
// Throughput: one byte per cycle while s_axis_tready is high; the parser updates its state for every byte.
// A two-entry output buffer keeps s_axis_tready high while one result waits.
// Reset clears parser state, payload_mode and the output buffer; no clearing pass.
// Depends on sfrc_pkg, sfrc_parser and sfrc_out_fifo.
module serial_frame_receiver_checksum #(
  parameter int LONG_PAYLOAD  = sfrc_pkg::LONG_PAYLOAD_DEF,
  parameter int SHORT_PAYLOAD = sfrc_pkg::SHORT_PAYLOAD_DEF,
  parameter int SHORT_FRAME   = sfrc_pkg::SHORT_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] body_byte, [16:8] body_index, [32:17] type_code, [48:33] packet_number,
  // [64:49] data_length, [65] checksum_ok, [71:66] zero
  output logic [71:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // payload_mode
);

  logic              mode_q;
  logic              accept;
  logic              push;
  sfrc_pkg::result_t res_in;
  sfrc_pkg::result_t res_out;

  assign cfg_ready_o = 1'b1;
  assign accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  sfrc_parser #(
    .LONG_PAYLOAD  (LONG_PAYLOAD),
    .SHORT_PAYLOAD (SHORT_PAYLOAD),
    .SHORT_FRAME   (SHORT_FRAME)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (s_axis_tdata),
    .payload_mode_i (mode_q),
    .push_o         (push),
    .result_o       (res_in)
  );

  sfrc_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (res_in),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (res_out)
  );

  assign m_axis_tdata = {6'b0, res_out.checksum_ok, res_out.data_length,
                         res_out.packet_number, res_out.type_code,
                         res_out.body_index, res_out.body_byte};
  assign m_axis_tuser = res_out.ev;

endmodule

// ===== verif/tb_serial_frame_receiver_checksum.sv =====
// Testbench for serial_frame_receiver_checksum: streams link bytes, predicts
// events and sum checks per byte, and compares every result transaction.
// Depends on sfrc_pkg and the serial_frame_receiver_checksum RTL.
`timescale 1ns / 100ps

module tb_serial_frame_receiver_checksum;

  typedef enum logic [1:0] {PRS_IDLE, PRS_HEAD, PRS_SHORT, PRS_DATA} prs_phase_e;
  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_stall_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;

  // predictor state
  prs_phase_e  prs_phase = PRS_IDLE;
  logic [9:0]  prs_pos = '0;
  logic [15:0] prs_sum = '0;
  logic [15:0] prs_type = '0;
  logic [15:0] prs_pnum = '0;
  logic [15:0] prs_len = '0;
  logic [15:0] prs_rxsum = '0;
  logic [8:0]  prs_payload = '0;
  logic        prs_mode = 1'b0;

  logic                cur_mode = 1'b0;
  logic [7:0]          link_bytes[$];
  sfrc_pkg::result_t   expected_events[$];
  sfrc_pkg::result_t   want_ev;
  int                  fail_count = 0;

  int          tx_burst = 0;
  int          tx_gap = 0;
  bit          tx_gaps_on = 1'b0;
  rx_stall_e   rx_mode = RX_ALWAYS;
  bit          rx_hold_req = 1'b0;
  int          rx_hold_left = 0;
  int          rx_cyc = 0;

  serial_frame_receiver_checksum uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void parse_rx_byte(input logic [7:0] b);
    sfrc_pkg::result_t r;
    bit                hit;
    int unsigned       p, flen, idx, lim;
    r = '0;
    hit = 1'b0;
    p = prs_pos;
    case (prs_phase)
      PRS_IDLE: begin
        hit = 1'b1;
        if (b == sfrc_pkg::LEAD_ACK) r.ev = sfrc_pkg::EV_ACK;
        else if (b == sfrc_pkg::LEAD_DONE) r.ev = sfrc_pkg::EV_DONE;
        else if (b == sfrc_pkg::LEAD_ENQ) r.ev = sfrc_pkg::EV_ENQ;
        else if (b != sfrc_pkg::LEAD_PKT) r.ev = sfrc_pkg::EV_BAD_LEAD;
        else begin
          hit = 1'b0;
          prs_phase = PRS_HEAD;
          prs_pos = 10'd1;
          prs_sum = '0;
          prs_type = '0;
          prs_pnum = '0;
          prs_len = '0;
          prs_rxsum = '0;
          prs_payload = '0;
        end
      end
      PRS_HEAD: begin
        prs_pos = 10'(p + 1);
        if (p != 1) begin
          prs_sum += b;
          prs_type = {prs_type[7:0], b};
          if (p != 2) begin
            if (prs_type == sfrc_pkg::TYPE_OK || prs_type == sfrc_pkg::TYPE_DE ||
                prs_type == sfrc_pkg::TYPE_SB) begin
              prs_phase = PRS_SHORT;
            end else if (prs_type == sfrc_pkg::TYPE_DT) begin
              prs_phase = PRS_DATA;
            end else begin
              prs_phase = PRS_IDLE;
              prs_pos = '0;
              hit = 1'b1;
              r.ev = sfrc_pkg::EV_UNKNOWN;
              r.type_code = prs_type;
            end
          end
        end
      end
      PRS_SHORT: begin
        flen = sfrc_pkg::SHORT_FRAME_DEF;
        prs_pos = 10'(p + 1);
        if (p + 4 < flen) begin
          prs_sum += b;
          hit = 1'b1;
          r.ev = sfrc_pkg::EV_BODY;
          r.body_byte = b;
          r.body_index = 9'(p - 4);
          r.type_code = prs_type;
        end else if (p + 4 == flen || p + 3 == flen) begin
          prs_rxsum = {prs_rxsum[7:0], b};
        end else if (p + 1 >= flen) begin
          prs_phase = PRS_IDLE;
          prs_pos = '0;
          hit = 1'b1;
          r.ev = sfrc_pkg::EV_SHORT_END;
          r.type_code = prs_type;
          r.checksum_ok = (prs_sum == prs_rxsum);
        end
      end
      default: begin
        prs_pos = 10'(p + 1);
        if (p < 8) begin
          prs_sum += b;
          if (p < 6) begin
            prs_pnum = {prs_pnum[7:0], b};
          end else begin
            prs_len = {prs_len[7:0], b};
            if (p == 7)
              prs_payload = (prs_mode || prs_len == sfrc_pkg::SHORT_PAYLOAD_DEF) ?
                            9'(sfrc_pkg::SHORT_PAYLOAD_DEF) :
                            9'(sfrc_pkg::LONG_PAYLOAD_DEF);
          end
        end else begin
          flen = 12 + prs_payload;
          if (p + 4 < flen) begin
            idx = p - 8;
            lim = (prs_len < prs_payload) ? prs_len : prs_payload;
            prs_sum += b;
            if (idx < lim) begin
              hit = 1'b1;
              r.ev = sfrc_pkg::EV_BODY;
              r.body_byte = b;
              r.body_index = 9'(idx);
              r.type_code = prs_type;
              r.packet_number = prs_pnum;
              r.data_length = prs_len;
            end
          end else if (p + 4 == flen || p + 3 == flen) begin
            prs_rxsum = {prs_rxsum[7:0], b};
          end else if (p + 1 >= flen) begin
            prs_phase = PRS_IDLE;
            prs_pos = '0;
            hit = 1'b1;
            r.ev = sfrc_pkg::EV_DATA_END;
            r.type_code = prs_type;
            r.packet_number = prs_pnum;
            r.data_length = prs_len;
            r.checksum_ok = (prs_sum == prs_rxsum);
          end
        end
      end
    endcase
    if (hit) expected_events.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
    if (expv !== actv) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, expv, actv);
      fail_count++;
    end
  endfunction

  // byte driver: bursts of random length, random gaps between them when tx_gaps_on is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_rx_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (link_bytes.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= link_bytes.pop_front();
          if (tx_burst > 0) begin
            tx_burst--;
          end else begin
            tx_burst = $urandom_range(0, 40);
            tx_gap = tx_gaps_on ? $urandom_range(1, 5) : 0;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          $display("%0t unexpected transaction: expected none actual event %0d data %0h",
                   $time, m_axis_tuser, m_axis_tdata);
          fail_count++;
        end else begin
          want_ev = expected_events.pop_front();
          check_field("event", 16'(want_ev.ev), 16'(m_axis_tuser));
          check_field("body_byte", 16'(want_ev.body_byte), 16'(m_axis_tdata[7:0]));
          check_field("body_index", 16'(want_ev.body_index), 16'(m_axis_tdata[16:8]));
          check_field("type_code", want_ev.type_code, m_axis_tdata[32:17]);
          check_field("packet_number", want_ev.packet_number, m_axis_tdata[48:33]);
          check_field("data_length", want_ev.data_length, m_axis_tdata[64:49]);
          check_field("checksum_ok", 16'(want_ev.checksum_ok), 16'(m_axis_tdata[65]));
        end
      end
      rx_cyc++;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold_left = 300;
        m_axis_tready <= 1'b0;
      end else if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:   m_axis_tready <= ((rx_cyc % 9) < 5);
        endcase
      end
    end
  end

  task automatic write_mode(input logic v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    prs_mode = v;
    cur_mode = v;
  endtask

  // waits until the sender is idle and every expected result has come, or until a timeout
  task automatic drain();
    int waited;
    waited = 0;
    while ((link_bytes.size() != 0 || s_axis_tvalid || expected_events.size() != 0)
           && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_events.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, expected_events.size());
      fail_count++;
      expected_events.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] add_head(input logic [15:0] ty);
    logic [7:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? sfrc_pkg::LEAD_PKT : 8'($urandom);
    link_bytes.push_back(sfrc_pkg::LEAD_PKT);
    link_bytes.push_back(junk);
    link_bytes.push_back(ty[15:8]);
    link_bytes.push_back(ty[7:0]);
    return 16'(ty[15:8]) + 16'(ty[7:0]);
  endfunction

  function automatic void add_tail(input logic [15:0] sum, input bit bad);
    logic [15:0] cs;
    cs = bad ? (sum ^ 16'($urandom_range(1, 65535))) : sum;
    link_bytes.push_back(cs[15:8]);
    link_bytes.push_back(cs[7:0]);
    link_bytes.push_back(8'($urandom));
    link_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_short(input logic [15:0] ty, input bit bad, input int fill);
    logic [15:0] sum;
    logic [7:0]  b;
    sum = add_head(ty);
    for (int i = 0; i < sfrc_pkg::SHORT_FRAME_DEF - 8; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      sum += b;
      link_bytes.push_back(b);
    end
    add_tail(sum, bad);
  endfunction

  function automatic void add_data(input logic [15:0] pn, input logic [15:0] len,
                                   input bit bad, input int fill);
    logic [15:0] sum;
    logic [7:0]  b;
    int          plen;
    plen = (cur_mode || len == sfrc_pkg::SHORT_PAYLOAD_DEF) ?
           sfrc_pkg::SHORT_PAYLOAD_DEF : sfrc_pkg::LONG_PAYLOAD_DEF;
    sum = add_head(sfrc_pkg::TYPE_DT);
    sum += pn[15:8];
    sum += pn[7:0];
    sum += len[15:8];
    sum += len[7:0];
    link_bytes.push_back(pn[15:8]);
    link_bytes.push_back(pn[7:0]);
    link_bytes.push_back(len[15:8]);
    link_bytes.push_back(len[7:0]);
    for (int i = 0; i < plen; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      sum += b;
      link_bytes.push_back(b);
    end
    add_tail(sum, bad);
  endfunction

  function automatic void add_unknown(input logic [15:0] ty);
    void'(add_head(ty));
  endfunction

  function automatic void random_traffic(input int n_bytes, input int long_budget);
    int          start, pick;
    logic [7:0]  v;
    logic [15:0] ty, len;
    start = link_bytes.size();
    while (link_bytes.size() - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        case ($urandom_range(0, 3))
          0: v = sfrc_pkg::LEAD_ACK;
          1: v = sfrc_pkg::LEAD_DONE;
          2: v = sfrc_pkg::LEAD_ENQ;
          default: v = 8'($urandom);
        endcase
        if (v == sfrc_pkg::LEAD_PKT) v = sfrc_pkg::LEAD_ENQ;
        link_bytes.push_back(v);
      end else if (pick < 28) begin
        ty = ($urandom_range(0, 1) == 0) ? 16'($urandom) : {8'h44, 8'($urandom)};
        while (ty == sfrc_pkg::TYPE_OK || ty == sfrc_pkg::TYPE_DE ||
               ty == sfrc_pkg::TYPE_SB || ty == sfrc_pkg::TYPE_DT)
          ty = 16'($urandom);
        add_unknown(ty);
      end else if (pick < 65) begin
        case ($urandom_range(0, 2))
          0: ty = sfrc_pkg::TYPE_OK;
          1: ty = sfrc_pkg::TYPE_DE;
          default: ty = sfrc_pkg::TYPE_SB;
        endcase
        add_short(ty, $urandom_range(0, 7) == 0, -1);
      end else begin
        case ($urandom_range(0, 5))
          0: len = 16'(sfrc_pkg::SHORT_PAYLOAD_DEF);
          1: len = 16'($urandom_range(0, 16));
          2: len = 16'($urandom_range(0, 140));
          3: len = 16'($urandom);
          4: len = 16'hffff;
          default: len = 16'h0000;
        endcase
        if (!cur_mode && len != sfrc_pkg::SHORT_PAYLOAD_DEF) begin
          if (long_budget > 0) long_budget--;
          else len = 16'(sfrc_pkg::SHORT_PAYLOAD_DEF);
        end
        add_data(16'($urandom), len, $urandom_range(0, 7) == 0, -1);
      end
    end
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_mode(1'b0);
    @(negedge clk_i);
    link_bytes.push_back(sfrc_pkg::LEAD_ACK);
    link_bytes.push_back(sfrc_pkg::LEAD_DONE);
    link_bytes.push_back(sfrc_pkg::LEAD_ENQ);
    link_bytes.push_back(8'h02);
    link_bytes.push_back(8'hff);
    add_unknown(16'h0000);
    add_unknown(16'hffff);
    add_unknown(16'h4458);
    add_short(sfrc_pkg::TYPE_OK, 1'b0, -1);
    add_short(sfrc_pkg::TYPE_DE, 1'b1, -1);
    add_short(sfrc_pkg::TYPE_SB, 1'b0, sfrc_pkg::LEAD_PKT);  // lead-like bytes inside a frame
    add_short(sfrc_pkg::TYPE_OK, 1'b0, 8'hff);
    add_data(16'h0000, 16'(sfrc_pkg::SHORT_PAYLOAD_DEF), 1'b0, -1);
    add_data(16'hffff, 16'hffff, 1'b0, -1);  // emission saturates at long payload
    drain();

    write_mode(1'b1);
    @(negedge clk_i);
    add_data(16'h00ff, 16'd600, 1'b0, -1);
    drain();

    // long receiver hold while the sender keeps offering bytes
    @(negedge clk_i);
    tx_gaps_on = 1'b1;
    rx_mode = RX_RANDOM;
    random_traffic(80, 0);
    rx_hold_req = 1'b1;
    drain();

    write_mode(1'b0);
    @(negedge clk_i);
    tx_gaps_on = 1'b0;
    rx_mode = RX_PATTERN;
    random_traffic(80, 0);
    drain();

    write_mode(1'b1);
    @(negedge clk_i);
    tx_gaps_on = 1'b1;
    rx_mode = RX_ALWAYS;
    random_traffic(70, 0);
    drain();

    if (fail_count == 0)
      $display("serial_frame_receiver_checksum verification clean");
    else
      $display("serial_frame_receiver_checksum verification failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("serial_frame_receiver_checksum verification failed");
    $finish;
  end

endmodule
